[rtl/core/lmph_pkg.sv]
// Shared types and constants of the peak-hold level meter.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package lmph_pkg;

  localparam int RAW_W  = 24;  // raw meter value, unsigned Q8.16
  localparam int LVL_W  = 17;  // level and peak, Q0.16 with full scale included
  localparam int DB_W   = 16;  // signed Q8.8 dB registers
  localparam int FULL_W = 15;  // unsigned Q7.8 dB full reduction
  localparam int IDX_W  = 2;   // configuration register index
  localparam int POS_W  = 5;   // leading-one position of the raw value
  localparam int FRAC_W = 16;  // fraction bits of the logarithm
  localparam int NUM_W  = 42;  // signed dB numerator in Q.32
  localparam int REM_W  = 41;  // divider remainder
  localparam int DVS_W  = 25;  // divider divisor
  localparam int Q_W    = 16;  // divider quotient

  typedef enum logic [IDX_W-1:0] {
    REG_METER_MODE = 2'd0,
    REG_FLOOR_DB   = 2'd1,
    REG_TOP_DB     = 2'd2,
    REG_FULL_RED   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              done;
    logic [POS_W-1:0]  pos;
    logic [FRAC_W-1:0] frac;
  } log_res_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quotient;
  } div_res_t;

  localparam logic signed [DB_W-1:0] FLOOR_DB_RST = -16'sd15360;
  localparam logic signed [DB_W-1:0] TOP_DB_RST   = 16'sd0;
  localparam logic [FULL_W-1:0]      FULL_RED_RST = 15'd6144;
  localparam logic [FULL_W-1:0]      FULL_RED_MIN = 15'd256;
  localparam logic signed [17:0]     ONE_DB       = 18'sd256;

  localparam logic [LVL_W-1:0] FULL_SCALE   = 17'h10000;
  localparam logic [LVL_W-1:0] PEAK_FALL    = 17'd1311;
  localparam logic [LVL_W-1:0] CHANGE_MIN   = 17'd131;
  localparam logic [14:0]      RELEASE_Q16  = 15'd22938;
  localparam logic [32:0]      RELEASE_RND  = 33'd32768;
  localparam logic [18:0]      DB_PER_LOG2  = 19'd394566;
  localparam logic signed [21:0] LOG2_BIAS  = 22'sd1048576;

endpackage

`default_nettype wire

[rtl/core/lmph_in_if.sv]
// Input channel of the level meter: one raw meter value per transaction.
// Depends on lmph_pkg for the field width.
`default_nettype none

interface lmph_in_if;
  logic                        valid;
  logic                        ready;
  logic [lmph_pkg::RAW_W-1:0]  raw_value;

  modport source (output valid, output raw_value, input ready);
  modport sink   (input valid, input raw_value, output ready);
endinterface

`default_nettype wire

[rtl/core/lmph_out_if.sv]
// Result channel of the level meter: level, peak and change flag per transaction.
// Depends on lmph_pkg for the field widths.
`default_nettype none

interface lmph_out_if;
  logic                        valid;
  logic                        ready;
  logic [lmph_pkg::LVL_W-1:0]  level;
  logic [lmph_pkg::LVL_W-1:0]  peak;
  logic                        changed;

  modport source (output valid, output level, output peak, output changed, input ready);
  modport sink   (input valid, input level, input peak, input changed, output ready);
endinterface

`default_nettype wire

[rtl/core/lmph_cfg_if.sv]
// Configuration write channel of the level meter: register index and data.
// Depends on lmph_pkg for the index width.
`default_nettype none

interface lmph_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lmph_pkg::IDX_W-1:0]  index;
  logic [15:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/lmph_log2.sv]
// Base-2 logarithm of a nonzero raw value: serial normalisation, then repeated
// squaring of the mantissa with a byte-serial multiplier. Depends on lmph_pkg.
`default_nettype none

module lmph_log2 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lmph_pkg::RAW_W-1:0]    value,
  output lmph_pkg::log_res_t                 res
);

  localparam int ITER_W = $clog2(lmph_pkg::FRAC_W);
  localparam logic [lmph_pkg::POS_W-1:0] POS_TOP = lmph_pkg::POS_W'(lmph_pkg::RAW_W - 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(lmph_pkg::FRAC_W - 1);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} lstate_t;

  lstate_t                        state_r;
  logic [31:0]                    m_r;
  logic [31:0]                    mb_r;
  logic [63:0]                    prod_r;
  logic [lmph_pkg::POS_W-1:0]     pos_r;
  logic [lmph_pkg::FRAC_W-1:0]    frac_r;
  logic [ITER_W-1:0]              iter_r;
  logic [1:0]                     dig_r;
  logic                           done_r;

  logic [39:0] sum;
  logic [63:0] prod_nxt;
  logic [31:0] m_nxt;

  // One byte of the multiplier per cycle; the accumulator shifts right by a byte.
  assign sum      = {8'd0, prod_r[63:32]} + 40'(m_r * mb_r[7:0]);
  assign prod_nxt = {sum, prod_r[31:8]};
  assign m_nxt    = prod_nxt[63] ? prod_nxt[63:32] : prod_nxt[62:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        L_IDLE: begin
          if (start) begin
            m_r     <= {value, 8'd0};
            pos_r   <= POS_TOP;
            frac_r  <= '0;
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (pos_r != '0 && !m_r[31]) begin
            m_r   <= m_r << 1;
            pos_r <= pos_r - 1'b1;
          end else begin
            mb_r    <= m_r;
            prod_r  <= '0;
            iter_r  <= '0;
            dig_r   <= '0;
            state_r <= L_SQR;
          end
        end
        L_SQR: begin
          if (dig_r == 2'd3) begin
            frac_r <= {frac_r[lmph_pkg::FRAC_W-2:0], prod_nxt[63]};
            m_r    <= m_nxt;
            mb_r   <= m_nxt;
            prod_r <= '0;
            iter_r <= iter_r + 1'b1;
            if (iter_r == ITER_LAST) begin
              state_r <= L_IDLE;
              done_r  <= 1'b1;
            end
          end else begin
            prod_r <= prod_nxt;
            mb_r   <= mb_r >> 8;
          end
          dig_r <= dig_r + 1'b1;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.pos  = pos_r;
  assign res.frac = frac_r;

endmodule

`default_nettype wire

[rtl/core/lmph_div.sv]
// Restoring divider, one quotient bit per cycle, for quotients below 2^16.
// Depends on lmph_pkg for widths and the result struct.
`default_nettype none

module lmph_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lmph_pkg::REM_W-1:0]    dividend,
  input  wire logic [lmph_pkg::DVS_W-1:0]    divisor,
  output lmph_pkg::div_res_t                 res
);

  localparam int DS_W  = lmph_pkg::DVS_W + lmph_pkg::Q_W - 1;
  localparam int CNT_W = $clog2(lmph_pkg::Q_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lmph_pkg::Q_W - 1);

  logic [lmph_pkg::REM_W-1:0] rem_r;
  logic [DS_W-1:0]            ds_r;
  logic [lmph_pkg::Q_W-1:0]   q_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic                       ge;

  assign ge = rem_r >= lmph_pkg::REM_W'(ds_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - lmph_pkg::REM_W'(ds_r);
        end
        q_r   <= {q_r[lmph_pkg::Q_W-2:0], ge};
        ds_r  <= ds_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        rem_r  <= dividend;
        ds_r   <= {divisor, (lmph_pkg::Q_W-1)'(0)};
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign res.done     = done_r;
  assign res.quotient = q_r;

endmodule

`default_nettype wire

[rtl/core/level_meter_peak_hold.sv]
// Peak-hold level meter. Each input transaction carries one raw meter value and
// yields exactly one result transaction holding the displayed level, the held
// peak marker and a flag that is set when either moved by more than 131 units
// of Q0.16. In level mode (meter_mode 0) the value is a linear gain in Q8.16; it
// is turned into decibels by a base-2 logarithm and placed between the floor
// and top registers. In gain reduction mode (meter_mode 1) the value is a
// reduction in dB and is divided by full_reduction_db. The level rises at once
// and releases by 0.35 of the gap per transaction; the peak follows rises, holds
// for HOLD_TICKS transactions and then falls by 0.02 per transaction, never
// below the level. One item is processed at a time. In level mode the
// leading-one search shifts the value one bit a cycle, and the 16 fraction
// bits of the logarithm come from 16 squarings on a byte-serial 32 by 8
// multiplier, followed by a restoring division; the division is skipped when
// the target is clamped. In reduction mode the result comes from the
// division. A zero gain or a clamped reduction skips the serial units. Input
// is taken again in the cycle after the result register is loaded, and a
// stalled output holds the finished result until the register is free. The
// next item is accepted while a finished result still waits on the output.
// Configuration writes are always accepted and must only be made while the
// block is idle.
`default_nettype none

module level_meter_peak_hold #(
  parameter int HOLD_TICKS = 24
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  lmph_in_if.sink           in_chan,
  lmph_out_if.source        out_chan,
  lmph_cfg_if.sink          cfg_chan
);

  localparam int HOLD_W = $clog2(HOLD_TICKS + 1);
  localparam logic [HOLD_W-1:0] HOLD_LOAD = HOLD_W'(HOLD_TICKS);
  localparam int LVL_W = lmph_pkg::LVL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOGW, S_MULT, S_SUBN, S_CHK, S_DIVW, S_REL, S_UPDL, S_UPDP
  } state_t;

  // Configuration registers.
  logic                              mode_r;
  logic signed [lmph_pkg::DB_W-1:0]  floor_r;
  logic signed [lmph_pkg::DB_W-1:0]  top_r;
  logic [lmph_pkg::FULL_W-1:0]       full_r;

  // Sequencer and meter state.
  state_t                            state_r;
  logic [lmph_pkg::RAW_W-1:0]        raw_r;
  logic signed [lmph_pkg::NUM_W-1:0] db_r;
  logic signed [lmph_pkg::NUM_W-1:0] num_r;
  logic [LVL_W-1:0]                  target_r;
  logic                              up_r;
  logic [LVL_W-1:0]                  dec_r;
  logic [LVL_W-1:0]                  shown_r;
  logic [LVL_W-1:0]                  prev_level_r;
  logic [LVL_W-1:0]                  peak_r;
  logic [HOLD_W-1:0]                 hold_r;

  // Serial unit control.
  logic                              log_go_r;
  logic                              div_go_r;
  logic [lmph_pkg::REM_W-1:0]        div_dvd_r;
  logic [lmph_pkg::DVS_W-1:0]        div_dvs_r;
  lmph_pkg::log_res_t                log_res;
  lmph_pkg::div_res_t                div_res;

  // Output register.
  logic                              out_valid_r;
  logic [LVL_W-1:0]                  out_level_r;
  logic [LVL_W-1:0]                  out_peak_r;
  logic                              out_changed_r;

  logic                              in_fire;
  logic                              out_free;

  // Effective dB range: at least 1 dB wide whatever the registers hold.
  logic signed [17:0]                floor_x;
  logic signed [17:0]                top_x;
  logic signed [17:0]                lo;
  logic signed [17:0]                hi;
  logic signed [17:0]                span;
  logic signed [lmph_pkg::NUM_W-1:0] lo_sh;
  logic signed [lmph_pkg::NUM_W-1:0] den;
  logic [lmph_pkg::FULL_W-1:0]       full_eff;

  logic signed [21:0]                log_g;
  logic signed [19:0]                db_k;
  logic signed [lmph_pkg::NUM_W-1:0] db_nxt;

  logic [LVL_W-1:0]                  gap;
  logic [32:0]                       rel_sum;
  logic [LVL_W-1:0]                  dec_nxt;

  logic [LVL_W-1:0]                  peak_nxt;
  logic [HOLD_W-1:0]                 hold_nxt;
  logic signed [LVL_W:0]             fall;
  logic [LVL_W-1:0]                  dl;
  logic [LVL_W-1:0]                  dp;
  logic                              changed_nxt;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign floor_x  = 18'(floor_r);
  assign top_x    = 18'(top_r);
  assign lo       = (floor_x < top_x - lmph_pkg::ONE_DB) ? floor_x : top_x - lmph_pkg::ONE_DB;
  assign hi       = (top_x > lo + lmph_pkg::ONE_DB) ? top_x : lo + lmph_pkg::ONE_DB;
  assign span     = hi - lo;
  assign lo_sh    = {lo, 24'd0};
  assign den      = {span, 24'd0};
  assign full_eff = (full_r < lmph_pkg::FULL_RED_MIN) ? lmph_pkg::FULL_RED_MIN : full_r;

  // dB in Q.32 from the Q.16 logarithm of the gain, which is biased by 16 octaves.
  assign log_g  = $signed({1'b0, log_res.pos, log_res.frac}) - lmph_pkg::LOG2_BIAS;
  assign db_k   = $signed({1'b0, lmph_pkg::DB_PER_LOG2});
  assign db_nxt = log_g * db_k;

  // Release step, rounded to nearest; only used when the target lies below.
  assign gap     = shown_r - target_r;
  assign rel_sum = 33'(gap * lmph_pkg::RELEASE_Q16) + lmph_pkg::RELEASE_RND;
  assign dec_nxt = rel_sum[32:16];

  // Peak hold and fall, then the change flag against the previous result.
  assign fall = $signed({1'b0, peak_r}) - $signed({1'b0, lmph_pkg::PEAK_FALL});

  always_comb begin
    priority if (shown_r >= peak_r) begin
      peak_nxt = shown_r;
      hold_nxt = HOLD_LOAD;
    end else if (hold_r != '0) begin
      peak_nxt = peak_r;
      hold_nxt = hold_r - 1'b1;
    end else begin
      peak_nxt = (fall > $signed({1'b0, shown_r})) ? fall[LVL_W-1:0] : shown_r;
      hold_nxt = hold_r;
    end
  end

  assign dl = (shown_r > prev_level_r) ? shown_r - prev_level_r : prev_level_r - shown_r;
  assign dp = (peak_nxt > peak_r) ? peak_nxt - peak_r : peak_r - peak_nxt;
  assign changed_nxt = (dl > lmph_pkg::CHANGE_MIN) || (dp > lmph_pkg::CHANGE_MIN);

  // Configuration writes are taken in any cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      floor_r <= lmph_pkg::FLOOR_DB_RST;
      top_r   <= lmph_pkg::TOP_DB_RST;
      full_r  <= lmph_pkg::FULL_RED_RST;
    end else if (cfg_chan.valid) begin
      unique case (lmph_pkg::cfg_reg_t'(cfg_chan.index))
        lmph_pkg::REG_METER_MODE: mode_r  <= cfg_chan.data[0];
        lmph_pkg::REG_FLOOR_DB:   floor_r <= $signed(cfg_chan.data);
        lmph_pkg::REG_TOP_DB:     top_r   <= $signed(cfg_chan.data);
        lmph_pkg::REG_FULL_RED:   full_r  <= cfg_chan.data[lmph_pkg::FULL_W-1:0];
        default:                  mode_r  <= mode_r;
      endcase
    end
  end

  // Sequencer: target computation, ballistics and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      log_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      shown_r     <= '0;
      peak_r      <= '0;
      hold_r      <= '0;
    end else begin
      log_go_r <= 1'b0;
      div_go_r <= 1'b0;
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            raw_r <= in_chan.raw_value;
            if (mode_r) begin
              // Reduction mode: clamp when the quotient would reach full scale.
              if (in_chan.raw_value >= lmph_pkg::RAW_W'({full_eff, 8'd0})) begin
                target_r <= lmph_pkg::FULL_SCALE;
                state_r  <= S_REL;
              end else begin
                div_dvd_r <= lmph_pkg::REM_W'({in_chan.raw_value, 8'd0});
                div_dvs_r <= lmph_pkg::DVS_W'(full_eff);
                div_go_r  <= 1'b1;
                state_r   <= S_DIVW;
              end
            end else if (in_chan.raw_value == '0) begin
              // A zero gain sits at the floor.
              target_r <= '0;
              state_r  <= S_REL;
            end else begin
              log_go_r <= 1'b1;
              state_r  <= S_LOGW;
            end
          end
        end
        S_LOGW: begin
          if (log_res.done) begin
            state_r <= S_MULT;
          end
        end
        S_MULT: begin
          db_r    <= db_nxt;
          state_r <= S_SUBN;
        end
        S_SUBN: begin
          num_r   <= db_r - lo_sh;
          state_r <= S_CHK;
        end
        S_CHK: begin
          priority if (num_r <= 0) begin
            target_r <= '0;
            state_r  <= S_REL;
          end else if (num_r >= den) begin
            target_r <= lmph_pkg::FULL_SCALE;
            state_r  <= S_REL;
          end else begin
            div_dvd_r <= num_r[lmph_pkg::REM_W-1:0];
            div_dvs_r <= {span[16:0], 8'd0};
            div_go_r  <= 1'b1;
            state_r   <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_res.done) begin
            target_r <= LVL_W'(div_res.quotient);
            state_r  <= S_REL;
          end
        end
        S_REL: begin
          up_r    <= target_r > shown_r;
          dec_r   <= dec_nxt;
          state_r <= S_UPDL;
        end
        S_UPDL: begin
          prev_level_r <= shown_r;
          shown_r      <= up_r ? target_r : shown_r - dec_r;
          state_r      <= S_UPDP;
        end
        S_UPDP: begin
          // The peak moves only once the result can be placed in the output register.
          if (out_free) begin
            peak_r        <= peak_nxt;
            hold_r        <= hold_nxt;
            out_valid_r   <= 1'b1;
            out_level_r   <= shown_r;
            out_peak_r    <= peak_nxt;
            out_changed_r <= changed_nxt;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  lmph_log2 u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_go_r),
    .value (raw_r),
    .res   (log_res)
  );

  lmph_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .res      (div_res)
  );

  assign in_chan.ready    = (state_r == S_IDLE);
  assign cfg_chan.ready   = 1'b1;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.level   = out_level_r;
  assign out_chan.peak    = out_peak_r;
  assign out_chan.changed = out_changed_r;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench of the peak-hold level meter: drives raw meter values and
// register writes, and checks every reading against a cycle-free model of the meter.
// Depends on lmph_pkg, the three channel interfaces and level_meter_peak_hold.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The hold time under test. The model below keeps its own copy of it.
  localparam int HOLD_TICKS = 24;
  // Far beyond the slowest correct run of roughly six hundred items, plus
  // stalls, the long hold-off and the reset.
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 150;
  // Mismatch lines are counted in full but only the first ones are printed.
  localparam int MAX_REPORTS = 100;

  // Arithmetic of the meter in Q0.16 and Q8.8 dB.
  localparam int  SCALE_FULL      = 65536;
  localparam int  ONE_DB_Q8       = 256;
  localparam int  RELEASE_GAIN    = 22938;  // 0.35 in Q.16
  localparam int  PEAK_DROP       = 1311;   // 0.02 in Q0.16
  localparam int  MOVE_THRESHOLD  = 131;    // 0.002 in Q0.16
  localparam longint DB_PER_OCTAVE = 394566;  // 20*log10(2) in Q.16

  typedef struct packed {
    logic [16:0] level;
    logic [16:0] peak;
    logic        changed;
  } meter_reading_t;

  logic clk;
  logic rst_n;

  lmph_in_if  in_chan();
  lmph_out_if out_chan();
  lmph_cfg_if cfg_chan();

  level_meter_peak_hold #(
    .HOLD_TICKS(HOLD_TICKS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Readings predicted for accepted raw values, oldest first.
  meter_reading_t pending_readings[$];

  // The model's copy of the registers.
  bit mode_reduction;
  int floor_q8;
  int top_q8;
  int full_red_q8;

  // The model's copy of the ballistics state.
  int shown_level;
  int held_peak;
  int hold_left;

  // Idling of the two sides in percent of cycles, and the long hold-off of the
  // result side, counted down by the process that drives the result ready.
  int send_idle_pct = 9;
  int recv_idle_pct = 49;
  int hold_off_left = 0;

  int mismatch_count = 0;
  int reading_count = 0;
  int cycle_count = 0;

  // State of the generator of raw values: a base value held for a run of ticks,
  // so that loud passages followed by quiet ones exercise release and peak hold.
  int          seg_left = 0;
  logic [23:0] seg_base = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model of the meter
  // ---------------------------------------------------------------------------

  // Base-2 logarithm of a nonzero value in Q.16: the integer part from the
  // leading one, the fraction from sixteen squarings of the mantissa in Q1.31.
  function automatic longint log2_q16(input logic [23:0] v);
    int          p;
    logic [63:0] m;
    longint      frac;
    p = 23;
    while (p > 0 && v[p] == 1'b0) p--;
    m = 64'(v) << (31 - p);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(p) * 65536 + frac;
  endfunction

  // Normalised target of one raw value under the current registers.
  function automatic int target_of(input logic [23:0] raw);
    int     lo;
    int     hi;
    int     divisor;
    longint quot;
    longint db_q32;
    longint num;
    longint den;
    if (mode_reduction) begin
      // A full reduction below 1 dB acts as 1 dB.
      divisor = (full_red_q8 < ONE_DB_Q8) ? ONE_DB_Q8 : full_red_q8;
      quot = (longint'(raw) * 256) / divisor;
      return (quot > SCALE_FULL) ? SCALE_FULL : int'(quot);
    end
    // The range is widened to at least 1 dB, the floor giving way first.
    lo = (floor_q8 < top_q8 - ONE_DB_Q8) ? floor_q8 : top_q8 - ONE_DB_Q8;
    hi = (top_q8 > lo + ONE_DB_Q8) ? top_q8 : lo + ONE_DB_Q8;
    // A zero gain sits on the floor.
    if (raw == 0)
      return 0;
    db_q32 = (log2_q16(raw) - longint'(16 * 65536)) * DB_PER_OCTAVE;
    num = db_q32 - longint'(lo) * 16777216;
    den = longint'(hi - lo) * 16777216;
    if (num <= 0)
      return 0;
    if (num >= den)
      return SCALE_FULL;
    return int'((num <<< 16) / den);
  endfunction

  // Advances the ballistics by one tick and returns the reading it shows.
  function automatic meter_reading_t predict_reading(input logic [23:0] raw);
    int             target;
    int             prev_level;
    int             prev_peak;
    int             gap;
    int             dl;
    int             dp;
    meter_reading_t r;
    target = target_of(raw);
    prev_level = shown_level;
    prev_peak = held_peak;
    // Instant attack; release by 0.35 of the gap, rounded, so that a gap of
    // one unit does not move at all.
    if (target > shown_level) begin
      shown_level = target;
    end else begin
      gap = shown_level - target;
      shown_level -= int'((longint'(gap) * RELEASE_GAIN + 32768) >>> 16);
    end
    // The peak follows rises, holds, and then falls but never below the level.
    if (shown_level >= held_peak) begin
      held_peak = shown_level;
      hold_left = HOLD_TICKS;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      held_peak = (held_peak - PEAK_DROP > shown_level) ? held_peak - PEAK_DROP : shown_level;
    end
    dl = shown_level - prev_level;
    dp = held_peak - prev_peak;
    if (dl < 0) dl = -dl;
    if (dp < 0) dp = -dp;
    r.level = 17'(shown_level);
    r.peak = 17'(held_peak);
    r.changed = (dl > MOVE_THRESHOLD) || (dp > MOVE_THRESHOLD);
    return r;
  endfunction

  function automatic void apply_register(input lmph_pkg::cfg_reg_t idx, input logic [15:0] data);
    case (idx)
      lmph_pkg::REG_METER_MODE: mode_reduction = data[0];
      lmph_pkg::REG_FLOOR_DB:   floor_q8 = int'($signed(data));
      lmph_pkg::REG_TOP_DB:     top_q8 = int'($signed(data));
      lmph_pkg::REG_FULL_RED:   full_red_q8 = int'(data[14:0]);
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    mode_reduction = 1'b0;
    floor_q8 = int'(lmph_pkg::FLOOR_DB_RST);
    top_q8 = int'(lmph_pkg::TOP_DB_RST);
    full_red_q8 = int'(lmph_pkg::FULL_RED_RST);
    shown_level = 0;
    held_peak = 0;
    hold_left = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Picks the next raw value. Most values stay near a base held for a run of
  // ticks; a few are silence, full scale or wholly random words.
  function automatic logic [23:0] pick_raw();
    int span;
    int pick;
    if (seg_left == 0) begin
      seg_left = $urandom_range(1, 40);
      if (mode_reduction) begin
        // Up to a quarter past the reduction that fills the meter.
        span = ((full_red_q8 < ONE_DB_Q8) ? ONE_DB_Q8 : full_red_q8) * 320;
        seg_base = 24'($urandom_range(0, span));
      end else begin
        // Spread evenly over octaves rather than over linear gain.
        seg_base = 24'($urandom()) >> $urandom_range(0, 23);
      end
    end
    seg_left--;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      return '0;
    if (pick == 1)
      return '1;
    if (pick == 2)
      return 24'($urandom());
    return seg_base ^ 24'($urandom_range(0, 15));
  endfunction

  // Offers one raw value, idling beforehand as the current pattern asks, and
  // predicts its reading once the transaction has been accepted. Valid is left
  // high so that a following item goes out back to back.
  task automatic send_raw(input logic [23:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.raw_value <= raw;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_readings.push_back(predict_reading(raw));
  endtask

  // Stops offering items and waits until every predicted reading has arrived.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic write_register(input lmph_pkg::cfg_reg_t idx, input logic [15:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= data;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    apply_register(idx, data);
  endtask

  // Writes all four registers once the meter has gone idle. The unused upper
  // bits of the mode word carry random values.
  task automatic program_meter(input bit md, input logic [15:0] fl, input logic [15:0] tp,
                               input logic [15:0] fr);
    drain_results();
    write_register(lmph_pkg::REG_METER_MODE, {15'($urandom()), md});
    write_register(lmph_pkg::REG_FLOOR_DB, fl);
    write_register(lmph_pkg::REG_TOP_DB, tp);
    write_register(lmph_pkg::REG_FULL_RED, fr);
    cfg_chan.valid <= 1'b0;
  endtask

  // Chooses a setting: the reset one, typical meter ranges, narrow and
  // inverted ranges, the widest range, or wholly random words.
  task automatic program_random_setting();
    bit          md;
    logic [15:0] fl;
    logic [15:0] tp;
    logic [15:0] fr;
    md = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: begin
        fl = 16'(lmph_pkg::FLOOR_DB_RST);
        tp = 16'(lmph_pkg::TOP_DB_RST);
      end
      1: begin
        fl = 16'($urandom());
        tp = 16'($urandom());
      end
      2: begin
        fl = 16'h8000;
        tp = 16'h7FFF;
      end
      3: begin
        tp = 16'($urandom_range(0, 6144)) - 16'd3072;
        fl = tp + 16'($urandom_range(0, 512)) - 16'd256;
      end
      default: begin
        fl = -16'($urandom_range(20 * 256, 90 * 256));
        tp = 16'($urandom_range(0, 22 * 256)) - 16'd2560;
      end
    endcase
    case ($urandom_range(5))
      0: fr = 16'($urandom_range(0, 255));
      1: fr = 16'h7FFF;
      default: fr = 16'($urandom_range(256, 50 * 256));
    endcase
    fr[15] = 1'($urandom_range(1));
    program_meter(md, fl, tp, fr);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("Mismatch at reading %0d: %s is %0d, expected %0d",
               reading_count, what, got, want);
    mismatch_count++;
  endtask

  // Every result transaction is compared field by field with the oldest
  // prediction. Outputs are sampled at the edge, before any update from it.
  always @(posedge clk) begin
    meter_reading_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      reading_count++;
      if (pending_readings.size() == 0) begin
        report_mismatch("level of a reading with none outstanding", out_chan.level, '0);
      end else begin
        want = pending_readings.pop_front();
        if (out_chan.level !== want.level)
          report_mismatch("level", out_chan.level, want.level);
        if (out_chan.peak !== want.peak)
          report_mismatch("peak", out_chan.peak, want.peak);
        if (out_chan.changed !== want.changed)
          report_mismatch("changed", 17'(out_chan.changed), 17'(want.changed));
      end
    end
  end

  // The result side takes readings at random, or not at all while a long
  // hold-off is counting down.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a meter that hangs ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d readings outstanding",
               cycle_count, pending_readings.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Level mode under the reset registers: silence, the smallest and largest
  // gains, unity gain at the top, and values inside the range.
  task automatic test_level_range();
    send_raw(24'h000000);
    send_raw(24'h000001);
    send_raw(24'hFFFFFF);
    send_raw(24'h010000);
    send_raw(24'h008000);
    send_raw(24'h000100);
  endtask

  // Ranges narrower than 1 dB: equal, inverted and at both ends of the word,
  // and the widest range there is.
  task automatic test_narrow_range();
    logic [15:0] fr;
    fr = 16'(lmph_pkg::FULL_RED_RST);
    program_meter(1'b0, 16'h0000, 16'h0000, fr);
    send_raw(24'h010000);
    send_raw(24'h00F000);
    program_meter(1'b0, 16'h7FFF, 16'h8000, fr);
    send_raw(24'h010000);
    send_raw(24'hFFFFFF);
    program_meter(1'b0, 16'h8000, 16'h7FFF, fr);
    send_raw(24'h000001);
    send_raw(24'hFFFFFF);
  endtask

  // Gain reduction mode: a full reduction below 1 dB, a clamped target, a
  // release gap of one unit that must leave the level where it is, silence,
  // and the largest full reduction.
  task automatic test_reduction();
    program_meter(1'b1, 16'(lmph_pkg::FLOOR_DB_RST), 16'(lmph_pkg::TOP_DB_RST), 16'h0000);
    send_raw(24'hFFFFFF);
    send_raw(24'h00FFFF);
    send_raw(24'h000000);
    send_raw(24'h000100);
    program_meter(1'b1, 16'(lmph_pkg::FLOOR_DB_RST), 16'(lmph_pkg::TOP_DB_RST), 16'hFFFF);
    send_raw(24'hFFFFFF);
    send_raw(24'h123456);
  endtask

  // Blocks of random ticks, each under a setting of its own, with the idling
  // pattern given.
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int blocks);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (blocks) begin
      program_random_setting();
      repeat ($urandom_range(20, 40)) send_raw(pick_raw());
    end
  endtask

  // The result side holds off for a long stretch while ticks keep coming, so
  // that the meter fills its output and must refuse further input.
  task automatic test_output_backpressure();
    program_meter(1'b0, 16'(lmph_pkg::FLOOR_DB_RST), 16'(lmph_pkg::TOP_DB_RST),
                  16'(lmph_pkg::FULL_RED_RST));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_left = 400;
    repeat (12) send_raw(pick_raw());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.raw_value <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= lmph_pkg::REG_METER_MODE;
    cfg_chan.data <= '0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The directed tests run under the first idling pattern: the sender idles
    // rarely and the receiver about half of the time.
    test_level_range();
    test_narrow_range();
    test_reduction();
    test_random_traffic(9, 49, 6);
    test_random_traffic(49, 9, 6);
    test_random_traffic(0, 0, 6);
    test_output_backpressure();

    // Every transaction is in; let the last readings arrive and then allow
    // for anything the meter might still send on its own.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
